// ===== sv/strict_priority_task_queue_macros.svh =====
// assertion macros shared by the task queue modules
// needs nothing else; included by the files that carry checks
`ifndef STRICT_PRIORITY_TASK_QUEUE_MACROS_SVH
`define STRICT_PRIORITY_TASK_QUEUE_MACROS_SVH

// property holds on every clock edge outside reset
`define SPQ_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// when pre holds, post holds in the next cycle
`define SPQ_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
// shared types and constants for the strict priority task queue
// no dependencies; imported by the interfaces, the top, the controller and the datapath
package spq_pkg;

  localparam int unsigned LEVELS_DEF = 3;
  localparam int unsigned DEPTH_DEF  = 16;

  localparam int unsigned CODE_W  = 16;
  localparam int unsigned ARG_W   = 32;
  localparam int unsigned PRIO_W  = 8;
  localparam int unsigned LEVEL_W = 2;
  localparam int unsigned TOTAL_W = 6;

  localparam logic CMD_ENQUEUE = 1'b0;
  localparam logic CMD_DEQUEUE = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [ARG_W-1:0]  arg;
    logic [PRIO_W-1:0] prio;
  } spq_entry_t;

  localparam int unsigned ENTRY_W = $bits(spq_entry_t);

  // commands from the controller to the datapath
  typedef struct packed {
    logic take_enq;
    logic take_deq;
    logic finish_deq;
  } spq_ctl_t;

endpackage

// ===== sv/spq_task_if.sv =====
// handshake channels of the task queue: request in, result out
// depends on spq_pkg for field widths
interface spq_task_if import spq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [CODE_W-1:0]        task_code;
  logic [ARG_W-1:0]         task_arg;
  logic signed [PRIO_W-1:0] priority_req;

  modport source (output valid, command, task_code, task_arg, priority_req, input ready);
  modport sink   (input valid, command, task_code, task_arg, priority_req, output ready);
endinterface

interface spq_result_if import spq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic                     task_valid;
  logic [CODE_W-1:0]        task_code_res;
  logic [ARG_W-1:0]         task_arg_res;
  logic signed [PRIO_W-1:0] task_priority;
  logic [LEVEL_W-1:0]       level;
  logic [TOTAL_W-1:0]       total_tasks;

  modport source (output valid, accepted, task_valid, task_code_res, task_arg_res,
                  task_priority, level, total_tasks, input ready);
  modport sink   (input valid, accepted, task_valid, task_code_res, task_arg_res,
                  task_priority, level, total_tasks, output ready);
endinterface

// ===== sv/strict_priority_task_queue.sv =====
// an enqueue result is presented in the cycle after its transfer; a dequeue result passes
// through the registered read of the task store and then the output register
// throughput: one enqueue per cycle while results drain; no request enters in a read
// a result waiting in the output register does not block the next request if drained
// reset (asynchronous, active low) empties every level and opens the queue; the
// task store itself is not cleared and needs no clearing pass
module strict_priority_task_queue import spq_pkg::*; #(
  parameter int unsigned LEVELS = LEVELS_DEF,
  parameter int unsigned DEPTH  = DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  spq_task_if.sink     task_i,
  spq_result_if.source result_o
);

  spq_ctl_t ctl;

  spq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (task_i.valid),
    .in_command_i (task_i.command),
    .in_ready_o   (task_i.ready),
    .out_ready_i  (result_o.ready),
    .out_valid_o  (result_o.valid),
    .ctl_o        (ctl)
  );

  spq_datapath #(
    .LEVELS (LEVELS),
    .DEPTH  (DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .ctl_i           (ctl),
    .task_code_i     (task_i.task_code),
    .task_arg_i      (task_i.task_arg),
    .priority_req_i  (task_i.priority_req),
    .accepted_o      (result_o.accepted),
    .task_valid_o    (result_o.task_valid),
    .task_code_res_o (result_o.task_code_res),
    .task_arg_res_o  (result_o.task_arg_res),
    .task_priority_o (result_o.task_priority),
    .level_o         (result_o.level),
    .total_tasks_o   (result_o.total_tasks)
  );

endmodule

// ===== sv/spq_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module spq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/spq_ctrl.sv =====
// controller of the task queue: handshakes, read wait state, result valid
// depends on spq_pkg and the assertion macro header
`include "strict_priority_task_queue_macros.svh"

module spq_ctrl import spq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_command_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output spq_ctl_t ctl_o
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   take;

  // a new request may enter while the held result drains in the same cycle
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign take       = in_valid_i && in_ready_o;

  assign ctl_o.take_enq   = take && (in_command_i == CMD_ENQUEUE);
  assign ctl_o.take_deq   = take && (in_command_i == CMD_DEQUEUE);
  assign ctl_o.finish_deq = (state_q == S_READ);

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (ctl_o.take_deq) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (ctl_o.take_enq || ctl_o.finish_deq) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `SPQ_ASSERT(a_read_slot_free, clk_i, rst_ni,
              (state_q != S_READ) || !out_valid_q,
              "result register busy during ram read")
  `SPQ_ASSERT_NEXT(a_deq_waits_read, clk_i, rst_ni, ctl_o.take_deq,
                   (state_q == S_READ) && !in_ready_o,
                   "dequeue did not enter read wait")
  `SPQ_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid_q && !out_ready_i,
                   out_valid_q,
                   "stalled result dropped")

endmodule

// ===== sv/spq_datapath.sv =====
// datapath of the task queue: level pointers and counts, task store, result register
// depends on spq_pkg, spq_ram and the assertion macro header
`include "strict_priority_task_queue_macros.svh"

module spq_datapath import spq_pkg::*; #(
  parameter int unsigned LEVELS = LEVELS_DEF,
  parameter int unsigned DEPTH  = DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  input  spq_ctl_t                 ctl_i,
  input  logic [CODE_W-1:0]        task_code_i,
  input  logic [ARG_W-1:0]         task_arg_i,
  input  logic signed [PRIO_W-1:0] priority_req_i,
  output logic                     accepted_o,
  output logic                     task_valid_o,
  output logic [CODE_W-1:0]        task_code_res_o,
  output logic [ARG_W-1:0]         task_arg_res_o,
  output logic signed [PRIO_W-1:0] task_priority_o,
  output logic [LEVEL_W-1:0]       level_o,
  output logic [TOTAL_W-1:0]       total_tasks_o
);

  localparam int unsigned LW        = $clog2(LEVELS);
  localparam int unsigned PW        = $clog2(DEPTH);
  localparam int unsigned CW        = $clog2(DEPTH + 1);
  localparam int unsigned RAM_DEPTH = LEVELS * (2 ** PW);

  logic               closed_q;
  logic [PW-1:0]      rptr_q [LEVELS];
  logic [PW-1:0]      rptr_d [LEVELS];
  logic [PW-1:0]      wptr_q [LEVELS];
  logic [PW-1:0]      wptr_d [LEVELS];
  logic [CW-1:0]      cnt_q  [LEVELS];
  logic [CW-1:0]      cnt_d  [LEVELS];
  logic [TOTAL_W-1:0] total_q;
  logic [TOTAL_W-1:0] total_d;

  logic [LW-1:0]      lvl_in;
  logic               enq_ok;
  logic               pick_hit;
  logic [LW-1:0]      pick_lvl;
  logic               deq_ok;
  logic               hit_q;
  logic [LW-1:0]      sel_lvl_q;

  spq_entry_t         wr_entry;
  spq_entry_t         rd_entry;

  logic                     accepted_q;
  logic                     task_valid_q;
  logic [CODE_W-1:0]        code_res_q;
  logic [ARG_W-1:0]         arg_res_q;
  logic signed [PRIO_W-1:0] prio_res_q;
  logic [LEVEL_W-1:0]       level_q;
  logic [TOTAL_W-1:0]       total_res_q;

  logic [TOTAL_W-1:0] level_sum;
  logic               level_over;

  // clamp the signed request onto a level, negative goes to level 0, the highest priority
  always_comb begin
    if (priority_req_i[PRIO_W-1]) begin
      lvl_in = '0;
    end else if ({1'b0, priority_req_i[PRIO_W-2:0]} >= PRIO_W'(LEVELS)) begin
      lvl_in = LW'(LEVELS - 1);
    end else begin
      lvl_in = priority_req_i[LW-1:0];
    end
  end

  assign enq_ok = ctl_i.take_enq && (task_code_i != '0) && !closed_q &&
                  (cnt_q[lvl_in] != CW'(DEPTH));

  // lowest numbered non-empty level wins
  always_comb begin
    pick_hit = 1'b0;
    pick_lvl = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (cnt_q[l] != '0) begin
        pick_hit = 1'b1;
        pick_lvl = LW'(l);
      end
    end
  end

  assign deq_ok = ctl_i.take_deq && pick_hit;

  always_comb begin
    for (int l = 0; l < LEVELS; l++) begin
      wptr_d[l] = wptr_q[l];
      rptr_d[l] = rptr_q[l];
      cnt_d[l]  = cnt_q[l];
      if (enq_ok && (lvl_in == LW'(l))) begin
        wptr_d[l] = (wptr_q[l] == PW'(DEPTH - 1)) ? '0 : wptr_q[l] + 1'b1;
        cnt_d[l]  = cnt_q[l] + 1'b1;
      end
      if (deq_ok && (pick_lvl == LW'(l))) begin
        rptr_d[l] = (rptr_q[l] == PW'(DEPTH - 1)) ? '0 : rptr_q[l] + 1'b1;
        cnt_d[l]  = cnt_q[l] - 1'b1;
      end
    end
  end

  // the held total wraps the same way the reported field does
  always_comb begin
    total_d = total_q;
    if (enq_ok) begin
      total_d = total_q + 1'b1;
    end else if (deq_ok) begin
      total_d = total_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_q <= 1'b0;
      total_q  <= '0;
      for (int l = 0; l < LEVELS; l++) begin
        rptr_q[l] <= '0;
        wptr_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        closed_q <= cfg_wdata_i;
      end
      total_q <= total_d;
      for (int l = 0; l < LEVELS; l++) begin
        rptr_q[l] <= rptr_d[l];
        wptr_q[l] <= wptr_d[l];
        cnt_q[l]  <= cnt_d[l];
      end
    end
  end

  assign wr_entry.code = task_code_i;
  assign wr_entry.arg  = task_arg_i;
  assign wr_entry.prio = priority_req_i;

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (enq_ok),
    .waddr_i ({lvl_in, wptr_q[lvl_in]}),
    .wdata_i (wr_entry),
    .re_i    (deq_ok),
    .raddr_i ({pick_lvl, rptr_q[pick_lvl]}),
    .rdata_o (rd_entry)
  );

  // result register, loaded at the enqueue transfer or when ram data lands
  always_ff @(posedge clk_i) begin
    if (ctl_i.take_deq) begin
      hit_q     <= pick_hit;
      sel_lvl_q <= pick_lvl;
    end
    if (ctl_i.take_enq) begin
      accepted_q   <= enq_ok;
      task_valid_q <= 1'b0;
      code_res_q   <= '0;
      arg_res_q    <= '0;
      prio_res_q   <= '0;
      level_q      <= '0;
      total_res_q  <= total_d;
    end else if (ctl_i.finish_deq) begin
      accepted_q   <= 1'b0;
      task_valid_q <= hit_q;
      code_res_q   <= hit_q ? rd_entry.code : '0;
      arg_res_q    <= hit_q ? rd_entry.arg : '0;
      prio_res_q   <= hit_q ? rd_entry.prio : '0;
      level_q      <= hit_q ? LEVEL_W'(sel_lvl_q) : '0;
      total_res_q  <= total_q;
    end
  end

  assign accepted_o      = accepted_q;
  assign task_valid_o    = task_valid_q;
  assign task_code_res_o = code_res_q;
  assign task_arg_res_o  = arg_res_q;
  assign task_priority_o = prio_res_q;
  assign level_o         = level_q;
  assign total_tasks_o   = total_res_q;

  always_comb begin
    level_sum  = '0;
    level_over = 1'b0;
    for (int l = 0; l < LEVELS; l++) begin
      level_sum = level_sum + TOTAL_W'(cnt_q[l]);
      if (cnt_q[l] > CW'(DEPTH)) begin
        level_over = 1'b1;
      end
    end
  end

  `SPQ_ASSERT(a_total_matches_levels, clk_i, rst_ni, total_q == level_sum,
              "total count differs from level counts")
  `SPQ_ASSERT(a_level_in_bounds, clk_i, rst_ni, !level_over,
              "level count above depth")
  `SPQ_ASSERT_NEXT(a_deq_drops_total, clk_i, rst_ni, deq_ok,
                   total_q == $past(total_q) - TOTAL_W'(1),
                   "dequeue did not lower total")

endmodule
